### rtl/pidwi_pkg.sv
`timescale 1ns / 1ps

package pidwi_pkg;

   localparam int ErrWidth   = 17;
   localparam int DiffWidth  = ErrWidth + 1;
   localparam int CsrWidth   = 16;
   localparam int IntgWidth  = 32;
   localparam int PropWidth  = ErrWidth + CsrWidth;
   localparam int IprdWidth  = IntgWidth + CsrWidth;
   localparam int DprdWidth  = DiffWidth + CsrWidth;
   localparam int SumWidth   = IprdWidth + 2;
   localparam int FracBits   = 8;
   localparam int ScaleWidth = SumWidth - FracBits;
   localparam int CsrAddrWidth = 3;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_TARGET,
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D,
      CSR_UPPER,
      CSR_LOWER,
      CSR_WINDOW
   } csr_index_type;

   // controller state after the latest item
   typedef struct packed {
      logic signed [ErrWidth-1:0]  last_error;
      logic signed [ErrWidth-1:0]  prior_error;
      logic signed [IntgWidth-1:0] integral;
   } state_type;

   // registered products of the three terms
   typedef struct packed {
      logic signed [PropWidth-1:0] prop;
      logic signed [IprdWidth-1:0] intg;
      logic signed [DprdWidth-1:0] deriv;
   } prod_type;

   // stage enables from the pipeline control
   typedef struct packed {
      logic load_state;
      logic load_prod;
      logic load_out;
   } pipe_en_type;

endpackage

### rtl/pidwi_integ.sv
`timescale 1ns / 1ps

module pidwi_integ (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic                                  mode,
   input  logic signed [15:0]                    measurement,
   input  logic signed [pidwi_pkg::ErrWidth-1:0] given_error,
   input  logic signed [pidwi_pkg::ErrWidth-1:0] given_prior_error,
   input  logic signed [15:0]                    target_value,
   input  logic        [15:0]                    integral_window,
   output pidwi_pkg::state_type                  state
);
   import pidwi_pkg::*;

   logic signed [ErrWidth-1:0]  last_error_ff, last_error_in;
   logic signed [ErrWidth-1:0]  prior_error_ff, prior_error_in;
   logic signed [IntgWidth-1:0] integral_ff, integral_in;
   logic        [ErrWidth-1:0]  magnitude;
   logic signed [IntgWidth:0]   integral_next;
   logic                        in_window;

   always_comb begin
      if (mode) begin
         last_error_in  = given_error;
         prior_error_in = given_prior_error;
      end else begin
         last_error_in  = {target_value[15], target_value} - {measurement[15], measurement};
         prior_error_in = last_error_ff;
      end
      // most negative error wraps to the right unsigned magnitude
      magnitude = last_error_in[ErrWidth-1] ? (~last_error_in + 1'b1) : last_error_in;
      in_window = magnitude < {{(ErrWidth-16){1'b0}}, integral_window};
      integral_next = {integral_ff[IntgWidth-1], integral_ff}
                    + {{(IntgWidth+1-ErrWidth){last_error_in[ErrWidth-1]}}, last_error_in};
      if (!in_window) begin
         integral_in = '0;
      end else if (integral_next[IntgWidth] != integral_next[IntgWidth-1]) begin
         integral_in = integral_next[IntgWidth] ? {1'b1, {(IntgWidth-1){1'b0}}}
                                                : {1'b0, {(IntgWidth-1){1'b1}}};
      end else begin
         integral_in = integral_next[IntgWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff  <= '0;
         prior_error_ff <= '0;
         integral_ff    <= '0;
      end else if (load) begin
         last_error_ff  <= last_error_in;
         prior_error_ff <= prior_error_in;
         integral_ff    <= integral_in;
      end
   end

   assign state.last_error  = last_error_ff;
   assign state.prior_error = prior_error_ff;
   assign state.integral    = integral_ff;

   a_window_zero_clears: assert property (@(posedge clock) disable iff (reset)
      load && integral_window == '0 |=> integral_ff == '0)
      else $error("integral not cleared with zero window");

   a_error_shift: assert property (@(posedge clock) disable iff (reset)
      load && !mode |=> prior_error_ff == $past(last_error_ff))
      else $error("previous error not shifted in measurement mode");

endmodule

### rtl/pidwi_mult.sv
`timescale 1ns / 1ps

module pidwi_mult (
   input  logic                 clock,
   input  logic                 load,
   input  pidwi_pkg::state_type state,
   input  logic signed [15:0]   gain_p,
   input  logic signed [15:0]   gain_i,
   input  logic signed [15:0]   gain_d,
   output pidwi_pkg::prod_type  prod
);
   import pidwi_pkg::*;

   prod_type                    prod_ff, prod_in;
   logic signed [DiffWidth-1:0] diff;

   always_comb begin
      diff = {state.last_error[ErrWidth-1], state.last_error}
           - {state.prior_error[ErrWidth-1], state.prior_error};
      prod_in.prop  = state.last_error * gain_p;
      prod_in.intg  = state.integral * gain_i;
      prod_in.deriv = diff * gain_d;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

### rtl/pidwi_sum.sv
`timescale 1ns / 1ps

module pidwi_sum (
   input  logic                clock,
   input  logic                load,
   input  pidwi_pkg::prod_type prod,
   input  logic signed [15:0]  drive_upper,
   input  logic signed [15:0]  drive_lower,
   output logic signed [15:0]  drive,
   output logic                clamped
);
   import pidwi_pkg::*;

   logic signed [SumWidth-1:0]   total;
   logic signed [ScaleWidth-1:0] scaled;
   logic signed [ScaleWidth-1:0] upper_ext;
   logic signed [ScaleWidth-1:0] lower_ext;
   logic signed [15:0]           drive_ff, drive_in;
   logic                         clamped_ff, clamped_in;

   always_comb begin
      total = {{(SumWidth-PropWidth){prod.prop[PropWidth-1]}}, prod.prop}
            + {{(SumWidth-IprdWidth){prod.intg[IprdWidth-1]}}, prod.intg}
            + {{(SumWidth-DprdWidth){prod.deriv[DprdWidth-1]}}, prod.deriv};
      // dropping the fraction bits floors toward minus infinity
      scaled    = total[SumWidth-1:FracBits];
      upper_ext = {{(ScaleWidth-16){drive_upper[15]}}, drive_upper};
      lower_ext = {{(ScaleWidth-16){drive_lower[15]}}, drive_lower};
      if (scaled > upper_ext) begin
         drive_in   = drive_upper;
         clamped_in = 1'b1;
      end else if (scaled < lower_ext) begin
         drive_in   = drive_lower;
         clamped_in = 1'b1;
      end else begin
         drive_in   = scaled[15:0];
         clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff   <= drive_in;
         clamped_ff <= clamped_in;
      end
   end

   assign drive   = drive_ff;
   assign clamped = clamped_ff;

endmodule

### rtl/pid_controller_windowed_integral_top.sv
`timescale 1ns / 1ps
// PID controller step with a windowed, saturating integral.
// req_ channel: one transfer is one controller step. req_tuser is the mode:
//   0 takes the measurement and forms the error from the setpoint, 1 loads
//   the error and the previous error from the given fields.
// rsp_ channel: exactly one result per step, in order: the clamped drive in
//   rsp_tdata and the limit flag in rsp_tuser.
// csr_ port: one register write per cycle with csr_we high; write only while
//   no step is in flight.
// Pipeline: a req_ transfer loads the state registers, then the product
//   registers, then the drive registers that raise rsp_tvalid (state update,
//   multiply, sum and clamp). Throughput: one step per cycle while rsp_tready does
//   not stall; the integral and error registers close their loop in the first stage.
// Reset clears the controller state, the registers and the pipeline valid flags;
//   req_tready is low during reset.
// A stall on rsp_tready holds the result; the two stages before it keep
//   filling, so up to two further steps are taken before req_tready drops.
module pid_controller_windowed_integral_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // measurement, given_error, given_prior_error, zero pad
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // drive
   output logic        rsp_tuser,   // clamped
   input  logic        csr_we,
   input  logic [pidwi_pkg::CsrAddrWidth-1:0] csr_addr,
   input  logic [pidwi_pkg::CsrWidth-1:0]     csr_wdata
);
   import pidwi_pkg::*;

   logic signed [15:0] target_ff, gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [15:0] upper_ff, lower_ff;
   logic        [15:0] window_ff;

   logic        v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic        out_free, s2_free, s1_free, req_xfer;
   pipe_en_type en;
   state_type   state;
   prod_type    prod;
   logic signed [15:0] drive;
   logic        clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         upper_ff  <= '0;
         lower_ff  <= '0;
         window_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_TARGET: target_ff <= csr_wdata;
            CSR_GAIN_P: gain_p_ff <= csr_wdata;
            CSR_GAIN_I: gain_i_ff <= csr_wdata;
            CSR_GAIN_D: gain_d_ff <= csr_wdata;
            CSR_UPPER:  upper_ff  <= csr_wdata;
            CSR_LOWER:  lower_ff  <= csr_wdata;
            CSR_WINDOW: window_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // each stage moves on when the one after it is empty or moving
   always_comb begin
      out_free = !v3_ff || rsp_tready;
      s2_free  = !v2_ff || out_free;
      s1_free  = !v1_ff || s2_free;
      req_tready = s1_free && !reset;
      req_xfer   = req_tvalid && req_tready;
      en.load_state = req_xfer;
      en.load_prod  = v1_ff && s2_free;
      en.load_out   = v2_ff && out_free;
      v1_in = s1_free ? req_xfer : v1_ff;
      v2_in = s2_free ? v1_ff : v2_ff;
      v3_in = out_free ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   pidwi_integ u_integ (
      .clock             (clock),
      .reset             (reset),
      .load              (en.load_state),
      .mode              (req_tuser),
      .measurement       (req_tdata[15:0]),
      .given_error       (req_tdata[32:16]),
      .given_prior_error (req_tdata[49:33]),
      .target_value      (target_ff),
      .integral_window   (window_ff),
      .state             (state)
   );

   pidwi_mult u_mult (
      .clock  (clock),
      .load   (en.load_prod),
      .state  (state),
      .gain_p (gain_p_ff),
      .gain_i (gain_i_ff),
      .gain_d (gain_d_ff),
      .prod   (prod)
   );

   pidwi_sum u_sum (
      .clock       (clock),
      .load        (en.load_out),
      .prod        (prod),
      .drive_upper (upper_ff),
      .drive_lower (lower_ff),
      .drive       (drive),
      .clamped     (clamped)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = drive;
   assign rsp_tuser  = clamped;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> v1_ff)
      else $error("accepted step missing from first stage");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rsp_tready && v2_ff |=> v2_ff && v3_ff)
      else $error("stalled result overwritten");

   a_out_advance: assert property (@(posedge clock) disable iff (reset)
      v2_ff && out_free |=> v3_ff)
      else $error("second stage result lost");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import pidwi_pkg::*;

   localparam logic ModeMeasure = 1'b0;
   localparam logic ModeDirect  = 1'b1;
   localparam longint IntegMax  = (64'sd1 <<< 31) - 1;
   localparam longint IntegMin  = -(64'sd1 <<< 31);
   localparam int MaxPrinted    = 40;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] measurement;
      logic signed [16:0] given_error;
      logic signed [16:0] given_prior;
   } step_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               clamped;
   } drive_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [55:0]   req_tdata = '0;  // measurement, given_error, given_prior_error, zero pad
   logic          req_tuser = 1'b0; // mode
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [15:0]   rsp_tdata;        // drive
   logic          rsp_tuser;        // clamped
   logic          csr_we = 1'b0;
   csr_index_type csr_addr = CSR_TARGET;
   logic [15:0]   csr_wdata = '0;

   step_type  step_queue[$];
   drive_type drive_owed[$];
   int        error_count = 0;

   // idling controls, set per phase
   int send_gap_max = 0;
   int rsp_gap_max = 0;
   int send_wait = 0;
   int rsp_wait = 0;
   bit long_stall_due = 1'b0;
   bit long_stall_done = 1'b0;
   int stall_left = 0;

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;

   // mirrored registers and controller state
   logic signed [15:0] cfg_target = '0, cfg_gain_p = '0, cfg_gain_i = '0, cfg_gain_d = '0;
   logic signed [15:0] cfg_upper = '0, cfg_lower = '0;
   logic        [15:0] cfg_window = '0;
   logic signed [16:0] err_now = '0;
   logic signed [31:0] integ = '0;

   pid_controller_windowed_integral_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic flag_error(string msg);
      error_count++;
      if (error_count <= MaxPrinted) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   // one controller step: updates error and integral, returns the clamped drive
   function automatic drive_type next_drive(step_type s);
      longint err, prev, mag, acc, total, q;
      drive_type r;
      if (s.mode == ModeMeasure) begin
         err = longint'(cfg_target) - longint'(s.measurement);
         prev = longint'(err_now);
      end else begin
         err = longint'(s.given_error);
         prev = longint'(s.given_prior);
      end
      err_now = err[16:0];
      mag = (err < 0) ? -err : err;
      if (mag < longint'(cfg_window)) begin
         acc = longint'(integ) + err;
         if (acc > IntegMax) acc = IntegMax;
         if (acc < IntegMin) acc = IntegMin;
         integ = acc[31:0];
      end else begin
         integ = '0;
      end
      total = err * longint'(cfg_gain_p) + longint'(integ) * longint'(cfg_gain_i)
            + (err - prev) * longint'(cfg_gain_d);
      q = total >>> FracBits;
      r.clamped = 1'b1;
      if (q > longint'(cfg_upper)) begin
         r.drive = cfg_upper;
      end else if (q < longint'(cfg_lower)) begin
         r.drive = cfg_lower;
      end else begin
         r.drive = q[15:0];
         r.clamped = 1'b0;
      end
      return r;
   endfunction

   // sampling, prediction and checking
   always @(posedge clock) begin
      step_type  s;
      drive_type want;
      req_taken <= !reset && req_tvalid && (req_tready === 1'b1);
      rsp_taken <= !reset && (rsp_tvalid === 1'b1) && rsp_tready;
      if (reset) begin
         cfg_target = '0; cfg_gain_p = '0; cfg_gain_i = '0; cfg_gain_d = '0;
         cfg_upper = '0; cfg_lower = '0; cfg_window = '0;
         err_now = '0;
         integ = '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_TARGET: cfg_target = csr_wdata;
               CSR_GAIN_P: cfg_gain_p = csr_wdata;
               CSR_GAIN_I: cfg_gain_i = csr_wdata;
               CSR_GAIN_D: cfg_gain_d = csr_wdata;
               CSR_UPPER:  cfg_upper = csr_wdata;
               CSR_LOWER:  cfg_lower = csr_wdata;
               CSR_WINDOW: cfg_window = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready === 1'b1) begin
            s.mode = req_tuser;
            s.measurement = req_tdata[15:0];
            s.given_error = req_tdata[32:16];
            s.given_prior = req_tdata[49:33];
            drive_owed.push_back(next_drive(s));
         end
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            if (drive_owed.size() == 0) begin
               flag_error($sformatf("result with nothing expected: drive %0d clamped %b",
                                    $signed(rsp_tdata), rsp_tuser));
            end else begin
               want = drive_owed.pop_front();
               if (rsp_tdata !== want.drive) begin
                  flag_error($sformatf("drive %0d, expected %0d",
                                       $signed(rsp_tdata), want.drive));
               end
               if (rsp_tuser !== want.clamped) begin
                  flag_error($sformatf("clamped %b, expected %b", rsp_tuser, want.clamped));
               end
            end
         end
      end
   end

   // sender
   always @(negedge clock) begin
      step_type cur;
      if (req_tvalid && !req_taken) begin
         // offer stays up until the transfer
      end else if (send_wait > 0) begin
         send_wait--;
         req_tvalid <= 1'b0;
      end else if (step_queue.size() != 0) begin
         cur = step_queue.pop_front();
         req_tdata <= {6'b0, cur.given_prior, cur.given_error, cur.measurement};
         req_tuser <= cur.mode;
         req_tvalid <= 1'b1;
         send_wait = $urandom_range(0, send_gap_max);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver
   always @(negedge clock) begin
      if (rsp_taken) rsp_wait = $urandom_range(0, rsp_gap_max);
      if (long_stall_due && !long_stall_done) begin
         stall_left = 400;
         long_stall_done = 1'b1;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
   endtask

   task automatic apply_settings(input logic [15:0] tgt, kp, ki, kd, up, lo, win);
      write_csr(CSR_TARGET, tgt);
      write_csr(CSR_GAIN_P, kp);
      write_csr(CSR_GAIN_I, ki);
      write_csr(CSR_GAIN_D, kd);
      write_csr(CSR_UPPER, up);
      write_csr(CSR_LOWER, lo);
      write_csr(CSR_WINDOW, win);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_step(logic mode, logic [15:0] meas, logic [16:0] gerr,
                            logic [16:0] gpri);
      step_type s;
      s.mode = mode;
      s.measurement = meas;
      s.given_error = gerr;
      s.given_prior = gpri;
      step_queue.push_back(s);
   endtask

   task automatic wait_drained();
      while (step_queue.size() != 0 || req_tvalid || drive_owed.size() != 0)
         @(posedge clock);
      // all results are in; leave a margin before the next phase
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [15:0] edgy16();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [16:0] edgy17();
      case ($urandom_range(0, 9))
         0: return 17'h10000;
         1: return 17'h0ffff;
         2: return 17'h1ffff;
         3: return 17'h00000;
         default: return 17'($urandom);
      endcase
   endfunction

   task automatic random_phase(int count, bit gentle, bit with_stall);
      logic [15:0] tgt, up, lo, win, meas;
      logic [16:0] gerr, gpri;
      logic        mode;
      if (gentle) begin
         tgt = 16'($urandom_range(0, 4000)) - 16'd2000;
         up = 16'h7fff;
         lo = 16'h8000;
         if ($urandom_range(0, 3) == 0) begin
            up = 16'($urandom_range(0, 20000));
            lo = -16'($urandom_range(0, 20000));
         end
         win = ($urandom_range(0, 5) == 0) ? 16'hffff : 16'($urandom_range(0, 3000));
         apply_settings(tgt, 16'($urandom_range(0, 1024)) - 16'd512,
                        16'($urandom_range(0, 1024)) - 16'd512,
                        16'($urandom_range(0, 1024)) - 16'd512, up, lo, win);
      end else begin
         tgt = edgy16();
         apply_settings(tgt, edgy16(), edgy16(), edgy16(), edgy16(), edgy16(), edgy16());
      end
      send_gap_max = (with_stall || $urandom_range(0, 2) == 0) ? 0 : 13;
      rsp_gap_max = (with_stall || $urandom_range(0, 2) == 0) ? 0 : 13;
      if (with_stall) long_stall_due = 1'b1;
      repeat (count) begin
         mode = ($urandom_range(0, 9) < 7) ? ModeMeasure : ModeDirect;
         meas = edgy16();
         gerr = edgy17();
         gpri = edgy17();
         if (gentle && $urandom_range(0, 7) != 0) begin
            meas = tgt + 16'($urandom_range(0, 6000)) - 16'd3000;
            gerr = 17'($urandom_range(0, 6000)) - 17'd3000;
            gpri = 17'($urandom_range(0, 6000)) - 17'd3000;
         end
         push_step(mode, meas, gerr, gpri);
      end
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, window edges, ignored fields
      send_gap_max = 13;
      rsp_gap_max = 13;
      apply_settings(16'd1000, 16'd256, 16'd16, 16'd128, 16'd20000, -16'd20000, 16'd5000);
      push_step(ModeMeasure, 16'd0, 17'h1ffff, 17'h10000);
      push_step(ModeMeasure, 16'd1000, 17'd0, 17'd0);
      push_step(ModeMeasure, 16'd990, 17'h0ffff, 17'h0ffff);
      push_step(ModeMeasure, 16'd1010, 17'd0, 17'd0);
      push_step(ModeMeasure, 16'h7fff, 17'd0, 17'd0);
      push_step(ModeMeasure, 16'h8000, 17'd0, 17'd0);
      push_step(ModeDirect, 16'h7fff, 17'h0ffff, 17'h10000);
      push_step(ModeDirect, 16'h8000, 17'h10000, 17'h0ffff);
      push_step(ModeDirect, 16'd0, 17'd4999, 17'd0);
      push_step(ModeDirect, 16'd0, 17'd5000, 17'd4999);
      push_step(ModeDirect, 16'd0, -17'd4999, 17'd5000);
      push_step(ModeDirect, 16'd0, -17'd5000, -17'd4999);
      push_step(ModeDirect, 16'd0, 17'd100, -17'd100);
      wait_drained();

      // crossed limits, zero window, gain extremes
      apply_settings(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, -16'd100, 16'd100, 16'd0);
      push_step(ModeMeasure, 16'h7fff, 17'd0, 17'd0);
      push_step(ModeMeasure, 16'h8000, 17'd0, 17'd0);
      push_step(ModeDirect, 16'd0, 17'd0, 17'd0);
      push_step(ModeDirect, 16'd0, 17'd1, 17'd0);
      push_step(ModeDirect, 16'd0, -17'd1, 17'd0);
      wait_drained();

      // widest window, error at and just inside its edge
      apply_settings(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'hffff);
      push_step(ModeMeasure, 16'h8000, 17'd0, 17'd0);
      push_step(ModeMeasure, 16'h8001, 17'd0, 17'd0);
      push_step(ModeMeasure, 16'h8001, 17'd0, 17'd0);
      push_step(ModeDirect, 16'd0, 17'h10000, 17'd0);
      push_step(ModeDirect, 16'd0, -17'd65534, 17'h0ffff);
      wait_drained();

      random_phase(210, 1'b1, 1'b0);
      random_phase(210, 1'b0, 1'b0);
      random_phase(210, 1'b1, 1'b1);
      random_phase(210, 1'b0, 1'b0);
      random_phase(210, 1'b1, 1'b0);
      random_phase(210, 1'b0, 1'b0);
      random_phase(210, 1'b1, 1'b0);
      random_phase(210, 1'b1, 1'b0);

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
